// File: rtl/bmm_pkg.sv
// bmm_pkg: shared constants for the Barrett modular multiplier.
// Register indexes, reset values, field widths and pipeline depth.
// No dependencies.
package bmm_pkg;

  // Operand width k, default
  localparam int unsigned WORD_BITS_DEFAULT = 32;

  // Fixed widths of the stream fields and registers
  localparam int unsigned FIELD_BITS = 32;
  localparam int unsigned MU_BITS    = 64;
  localparam int unsigned IN_TDATA_BITS  = 2 * FIELD_BITS;
  localparam int unsigned OUT_TDATA_BITS = FIELD_BITS;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MODULUS = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MU      = 1'b1;

  // Reset values
  localparam logic [FIELD_BITS-1:0] MODULUS_RESET = 32'd4294967291;
  localparam logic [MU_BITS-1:0]    MU_RESET      = 64'd4294967301;

  // Register stages from input to output register
  localparam int unsigned NUM_STAGES = 7;

endpackage

// File: rtl/barrett_modular_multiplier.sv
// barrett_modular_multiplier: pipelined (a * b) mod p by Barrett reduction.
// Depends on bmm_pkg for widths, register indexes and reset values.
//
// Usage:
//   Slave stream carries one operand pair per transfer: operand_a in
//   tdata[31:0], operand_b in tdata[63:32]; only the low WORD_BITS of each
//   are used. Master stream returns product_mod in tdata[31:0].
//   Config port: cfg_we_i writes cfg_data_i to register cfg_idx_i at the
//   clock edge (index 0 = modulus, 1 = barrett_mu = floor(2^2k / p)).
//   Write config only while the pipeline is empty.
//   Pipeline: each operand pair passes in order through the seven register
//   stages: a*b, four partial products of prod*mu, middle-term sum,
//   quotient sum, q*p partial products, remainder, final correction.
//   Throughput: one transfer per cycle while the master stream accepts
//   results; every multiplier is k by k bits.
//   Stalls: each stage has its own valid bit and loads when it is empty
//   or its successor moves, so bubbles collapse and input is still taken
//   while a result waits, until all seven stages are full.
//   Reset: all valid bits clear, modulus = 4294967291, mu = 4294967301.
module barrett_modular_multiplier #(
  parameter int unsigned WORD_BITS = bmm_pkg::WORD_BITS_DEFAULT
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // config write port
  input  logic                                    cfg_we_i,
  input  logic [bmm_pkg::CFG_IDX_BITS-1:0]        cfg_idx_i,
  input  logic [bmm_pkg::MU_BITS-1:0]             cfg_data_i,
  // operand stream
  input  logic                                    s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  input  logic [bmm_pkg::IN_TDATA_BITS-1:0]       s_axis_tdata_i,  // operand_a, operand_b
  // result stream
  output logic                                    m_axis_tvalid_o,
  input  logic                                    m_axis_tready_i,
  output logic [bmm_pkg::OUT_TDATA_BITS-1:0]      m_axis_tdata_o   // product_mod
);

  localparam int unsigned K  = WORD_BITS;
  localparam int unsigned K2 = 2 * WORD_BITS;
  localparam int unsigned K4 = 4 * WORD_BITS;
  localparam int unsigned NS = bmm_pkg::NUM_STAGES;
  localparam int unsigned FB = bmm_pkg::FIELD_BITS;

  // ---------------- configuration registers ----------------
  logic [K-1:0]  modulus_q;
  logic [K2-1:0] mu_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= bmm_pkg::MODULUS_RESET[K-1:0];
      mu_q      <= bmm_pkg::MU_RESET[K2-1:0];
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bmm_pkg::REG_MODULUS: modulus_q <= cfg_data_i[K-1:0];
        bmm_pkg::REG_MU:      mu_q      <= cfg_data_i[K2-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- stage valids and advance chain ----------------
  logic [NS:1] vld_q, vld_d;
  logic [NS:1] adv;

  always_comb begin
    adv[NS] = !vld_q[NS] || m_axis_tready_i;
    for (int i = NS - 1; i >= 1; i--) begin
      adv[i] = !vld_q[i] || adv[i+1];
    end
    vld_d = vld_q;
    if (adv[1]) vld_d[1] = s_axis_tvalid_i;
    for (int i = 2; i <= NS; i++) begin
      if (adv[i]) vld_d[i] = vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_axis_tready_o = adv[1];
  assign m_axis_tvalid_o = vld_q[NS];

  // ---------------- datapath ----------------
  logic [K-1:0] op_a, op_b;
  assign op_a = s_axis_tdata_i[K-1:0];
  assign op_b = s_axis_tdata_i[FB+K-1:FB];

  // stage 1: prod = a * b
  logic [K2-1:0] prod1_q, prod1_d;
  assign prod1_d = K2'(op_a) * K2'(op_b);
  always_ff @(posedge clk_i) begin
    if (adv[1]) prod1_q <= prod1_d;
  end

  // stage 2: partial products of prod * mu, halves of k bits
  logic [K2-1:0] pp_ll_q, pp_lh_q, pp_hl_q, pp_hh_q, prod2_q;
  logic [K-1:0]  p_lo, p_hi, mu_lo, mu_hi;
  assign p_lo  = prod1_q[K-1:0];
  assign p_hi  = prod1_q[K2-1:K];
  assign mu_lo = mu_q[K-1:0];
  assign mu_hi = mu_q[K2-1:K];
  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      pp_ll_q <= K2'(p_lo) * K2'(mu_lo);
      pp_lh_q <= K2'(p_lo) * K2'(mu_hi);
      pp_hl_q <= K2'(p_hi) * K2'(mu_lo);
      pp_hh_q <= K2'(p_hi) * K2'(mu_hi);
      prod2_q <= prod1_q;
    end
  end

  // stage 3: middle terms summed
  logic [K2:0]   mid3_q;
  logic [K2-1:0] ll3_q, hh3_q, prod3_q;
  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      mid3_q  <= (K2+1)'(pp_lh_q) + (K2+1)'(pp_hl_q);
      ll3_q   <= pp_ll_q;
      hh3_q   <= pp_hh_q;
      prod3_q <= prod2_q;
    end
  end

  // stage 4: quotient estimate = high 2k bits of the 4k-bit product
  logic [K4-1:0] full4;
  logic [K2-1:0] q4_q, prod4_q;
  assign full4 = {hh3_q, ll3_q} + (K4'(mid3_q) << K);
  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      q4_q    <= full4[K4-1:K2];
      prod4_q <= prod3_q;
    end
  end

  // stage 5: q * p, only the low 2k bits matter
  logic [K2-1:0] qp_lo5_q, prod5_q, qp_hi_full;
  logic [K-1:0]  qp_hi5_q;
  assign qp_hi_full = K2'(q4_q[K2-1:K]) * K2'(modulus_q);
  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      qp_lo5_q <= K2'(q4_q[K-1:0]) * K2'(modulus_q);
      qp_hi5_q <= qp_hi_full[K-1:0];
      prod5_q  <= prod4_q;
    end
  end

  // stage 6: remainder, wraps mod 2^2k
  logic [K2-1:0] r6_q;
  always_ff @(posedge clk_i) begin
    if (adv[6]) r6_q <= prod5_q - (qp_lo5_q + {qp_hi5_q, K'(0)});
  end

  // stage 7: one conditional subtraction, truncate to k bits
  logic [K2-1:0] r7_full;
  logic [K-1:0]  res_q;
  assign r7_full = (r6_q >= K2'(modulus_q)) ? (r6_q - K2'(modulus_q)) : r6_q;
  always_ff @(posedge clk_i) begin
    if (adv[7]) res_q <= r7_full[K-1:0];
  end

  assign m_axis_tdata_o = bmm_pkg::OUT_TDATA_BITS'(res_q);

  // ---------------- assertions ----------------
  // empty output stage means the whole chain can advance
  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled while output stage empty");

  // input only backs up once every stage holds an item
  a_full_when_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (&vld_q))
    else $error("input stalled with a bubble in the pipeline");

  // an accepted pair lands in stage 1
  a_accept_to_stage1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> vld_q[1])
    else $error("accepted operands lost at stage 1");

endmodule
